### design/udp_port_socket_table_macros.svh
// assertion macros for the udp port socket table
`ifndef UDP_PORT_SOCKET_TABLE_MACROS_SVH
`define UDP_PORT_SOCKET_TABLE_MACROS_SVH

// same-cycle implication
`define UPST_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("upst check failed");

// next-cycle implication
`define UPST_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("upst check failed");

`endif

### design/upst_pkg.sv
// shared constants and types for the udp port socket table
`default_nettype none
package upst_pkg;
	localparam int SOCKETS     = 8;
	localparam int SLOT_W      = 3;
	localparam int MAX_PAYLOAD = 1024;
	localparam int IDX_W       = 10;
	localparam int ADDR_W      = SLOT_W + IDX_W;
	localparam logic [15:0] EPH_BASE = 16'd49152;

	localparam logic [1:0] REQ_OPEN  = 2'd0;
	localparam logic [1:0] REQ_CLOSE = 2'd1;
	localparam logic [1:0] REQ_DELIV = 2'd2;
	localparam logic [1:0] REQ_RECV  = 2'd3;

	localparam logic [3:0] ST_OPENED   = 4'd0;
	localparam logic [3:0] ST_BUSY     = 4'd1;
	localparam logic [3:0] ST_FULL     = 4'd2;
	localparam logic [3:0] ST_CLOSED   = 4'd3;
	localparam logic [3:0] ST_BADH     = 4'd4;
	localparam logic [3:0] ST_QUEUED   = 4'd5;
	localparam logic [3:0] ST_DROPPED  = 4'd6;
	localparam logic [3:0] ST_BYTE     = 4'd7;
	localparam logic [3:0] ST_NODATA   = 4'd8;
	localparam logic [3:0] ST_BADRECV  = 4'd9;

	typedef struct packed {
		logic latch;
		logic srch;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic eph;
		logic srch_done;
	} sts_t;
endpackage
`default_nettype wire

### design/udp_port_socket_table.sv
// top level of the udp port socket table
//  channel | handshake          | payload
//  request | in_valid/in_ready   | req_type .. last
//  result  | out_valid/out_ready | status .. open_count
// a request passes the states idle, search (ephemeral opens only, up to 8 candidates), read and finish
// the read state waits for the registered memory read of the payload store
// one request is in flight at a time; a stalled result holds the next one back
// reset clears the socket table and sets the ephemeral pointer to 49152
`default_nettype none
`include "udp_port_socket_table_macros.svh"
module udp_port_socket_table import upst_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [15:0] port,
	input  wire logic [3:0]  handle,
	input  wire logic [31:0] src_ip,
	input  wire logic [15:0] peer_udp,
	input  wire logic [10:0] pkt_total,
	input  wire logic [10:0] byte_index,
	input  wire logic [7:0]  data_byte,
	input  wire logic [15:0] read_cap,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       status,
	output logic [3:0]       handle_out,
	output logic [10:0]      rx_length,
	output logic [31:0]      src_ip_out,
	output logic [15:0]      peer_udp_out,
	output logic [7:0]       data_out,
	output logic [3:0]       open_count
);
	cmd_t cmd;
	sts_t sts;

	upst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
	);

	upst_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req_type(req_type), .port(port), .handle(handle), .src_ip(src_ip),
		.peer_udp(peer_udp), .pkt_total(pkt_total), .byte_index(byte_index),
		.data_byte(data_byte), .read_cap(read_cap), .last(last),
		.status(status), .handle_out(handle_out), .rx_length(rx_length),
		.src_ip_out(src_ip_out), .peer_udp_out(peer_udp_out),
		.data_out(data_out), .open_count(open_count)
	);

	`UPST_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)
	`UPST_ASSERT_IMP(a_count_range, out_valid, open_count <= 4'(SOCKETS))
	`UPST_ASSERT_IMP(a_handle_only_open, out_valid && handle_out != 4'd0, status == ST_OPENED)
	`UPST_ASSERT_IMP(a_len_only_byte, out_valid && rx_length != 11'd0, status == ST_BYTE)
endmodule
`default_nettype wire

### design/upst_ctrl.sv
// controller state machine for the socket table
`default_nettype none
module upst_ctrl import upst_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      cmd,
	input  sts_t      sts
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SRCH = 2'd1;
	localparam logic [1:0] S_RD   = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q, state_nx;
	logic out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx  = state_q;
		cmd.latch = 1'b0;
		cmd.srch  = 1'b0;
		cmd.fin   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_nx  = sts.eph ? S_SRCH : S_RD;
				end
			end
			S_SRCH: begin
				cmd.srch = 1'b1;
				if (sts.srch_done) state_nx = S_RD;
			end
			S_RD: state_nx = S_FIN;
			S_FIN: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.fin  = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.fin) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

### design/upst_dp.sv
// socket table, payload memory and result register
`default_nettype none
module upst_dp import upst_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  wire logic [1:0]  req_type,
	input  wire logic [15:0] port,
	input  wire logic [3:0]  handle,
	input  wire logic [31:0] src_ip,
	input  wire logic [15:0] peer_udp,
	input  wire logic [10:0] pkt_total,
	input  wire logic [10:0] byte_index,
	input  wire logic [7:0]  data_byte,
	input  wire logic [15:0] read_cap,
	input  wire logic        last,
	output logic [3:0]       status,
	output logic [3:0]       handle_out,
	output logic [10:0]      rx_length,
	output logic [31:0]      src_ip_out,
	output logic [15:0]      peer_udp_out,
	output logic [7:0]       data_out,
	output logic [3:0]       open_count
);
	logic [SOCKETS-1:0] used_q, rdy_q, used_nx;
	logic [15:0] port_q [SOCKETS];
	logic [31:0] sip_q  [SOCKETS];
	logic [15:0] sprt_q [SOCKETS];
	logic [10:0] len_q  [SOCKETS];
	logic [15:0] eph_q;

	logic [1:0]  r_req_q;
	logic [15:0] r_port_q, r_sprt_q, r_bsize_q, lp_q;
	logic [3:0]  r_h_q;
	logic [31:0] r_sip_q;
	logic [10:0] r_plen_q, r_bidx_q;
	logic [7:0]  r_byte_q;
	logic        r_last_q;
	logic [SLOT_W-1:0] idx_q;

	logic [7:0] mem [2**ADDR_W];
	logic [7:0] rdata_q;

	function automatic logic [SOCKETS-1:0] match(input logic [SOCKETS-1:0] u,
		input logic [15:0] p [SOCKETS], input logic [15:0] x);
		logic [SOCKETS-1:0] m;
		for (int i = 0; i < SOCKETS; i++) m[i] = u[i] && (p[i] == x);
		return m;
	endfunction

	// candidate search, one per cycle
	logic [15:0] cand;
	logic cand_free;
	assign cand      = eph_q + 16'(idx_q);
	assign cand_free = ~|match(used_q, port_q, cand);
	assign sts = '{eph: (req_type == REQ_OPEN) && (port == 16'd0),
		srch_done: cand_free || (idx_q == SLOT_W'(SOCKETS - 1))};

	// finishing logic
	logic [SLOT_W-1:0] hs, free_s, dm_s;
	logic h_ok, free_any, open_busy, dm_any;
	logic [SOCKETS-1:0] dm;
	logic [10:0] rxl;

	assign hs   = SLOT_W'(r_h_q - 4'd1);
	assign h_ok = (r_h_q != 4'd0) && (r_h_q <= 4'(SOCKETS)) && used_q[hs];
	assign open_busy = (lp_q == 16'd0) || (|match(used_q, port_q, lp_q));
	assign dm = (r_plen_q <= 11'(MAX_PAYLOAD)) ? match(used_q, port_q, r_port_q) : '0;
	assign dm_any = |dm;
	assign rxl = ({5'd0, len_q[hs]} > r_bsize_q) ? r_bsize_q[10:0] : len_q[hs];

	always_comb begin
		free_any = 1'b0;
		free_s   = '0;
		dm_s     = '0;
		for (int i = SOCKETS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_any = 1'b1;
				free_s   = SLOT_W'(i);
			end
			if (dm[i]) dm_s = SLOT_W'(i);
		end
	end

	always_comb begin
		used_nx = used_q;
		if (r_req_q == REQ_OPEN && !open_busy && free_any) used_nx[free_s] = 1'b1;
		if (r_req_q == REQ_CLOSE && h_ok) used_nx[hs] = 1'b0;
	end

	logic [3:0] cnt;
	always_comb begin
		cnt = '0;
		for (int i = 0; i < SOCKETS; i++) cnt = cnt + 4'(used_nx[i]);
	end

	// payload memory
	always_ff @(posedge clk) begin
		if (cmd.fin && r_req_q == REQ_DELIV && dm_any && r_bidx_q < r_plen_q)
			mem[{dm_s, r_bidx_q[IDX_W-1:0]}] <= r_byte_q;
		rdata_q <= mem[{hs, r_bidx_q[IDX_W-1:0]}];
	end

	// latched request and result register
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			r_req_q   <= req_type;
			r_port_q  <= port;
			lp_q      <= port;
			r_h_q     <= handle;
			r_sip_q   <= src_ip;
			r_sprt_q  <= peer_udp;
			r_plen_q  <= pkt_total;
			r_bidx_q  <= byte_index;
			r_byte_q  <= data_byte;
			r_bsize_q <= read_cap;
			r_last_q  <= last;
			idx_q     <= '0;
		end else if (cmd.srch) begin
			if (cand_free) lp_q <= cand;
			else idx_q <= idx_q + SLOT_W'(1);
		end
		if (cmd.fin) begin
			handle_out   <= '0;
			rx_length    <= '0;
			src_ip_out   <= '0;
			peer_udp_out <= '0;
			data_out     <= '0;
			open_count   <= cnt;
			case (r_req_q)
				REQ_OPEN: begin
					if (open_busy) status <= ST_BUSY;
					else if (!free_any) status <= ST_FULL;
					else begin
						status     <= ST_OPENED;
						handle_out <= 4'(free_s) + 4'd1;
					end
				end
				REQ_CLOSE: status <= h_ok ? ST_CLOSED : ST_BADH;
				REQ_DELIV: status <= dm_any ? ST_QUEUED : ST_DROPPED;
				REQ_RECV: begin
					if (!h_ok) status <= ST_BADRECV;
					else if (!rdy_q[hs]) status <= ST_NODATA;
					else begin
						status       <= ST_BYTE;
						rx_length    <= rxl;
						src_ip_out   <= sip_q[hs];
						peer_udp_out <= sprt_q[hs];
						data_out     <= (r_bidx_q < rxl) ? rdata_q : 8'd0;
					end
				end
				default: status <= ST_BADRECV;
			endcase
		end
	end

	// socket table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			rdy_q  <= '0;
			eph_q  <= EPH_BASE;
			for (int i = 0; i < SOCKETS; i++) begin
				port_q[i] <= '0;
				sip_q[i]  <= '0;
				sprt_q[i] <= '0;
				len_q[i]  <= '0;
			end
		end else begin
			if (cmd.srch && cand_free) eph_q <= cand + 16'd1;
			if (cmd.fin) begin
				used_q <= used_nx;
				case (r_req_q)
					REQ_OPEN: begin
						if (!open_busy && free_any) begin
							port_q[free_s] <= lp_q;
							sip_q[free_s]  <= '0;
							sprt_q[free_s] <= '0;
							len_q[free_s]  <= '0;
							rdy_q[free_s]  <= 1'b0;
						end
					end
					REQ_CLOSE: begin
						if (h_ok) begin
							port_q[hs] <= '0;
							sip_q[hs]  <= '0;
							sprt_q[hs] <= '0;
							len_q[hs]  <= '0;
							rdy_q[hs]  <= 1'b0;
						end
					end
					REQ_DELIV: begin
						if (dm_any && r_last_q) begin
							sip_q[dm_s]  <= r_sip_q;
							sprt_q[dm_s] <= r_sprt_q;
							len_q[dm_s]  <= r_plen_q;
							rdy_q[dm_s]  <= 1'b1;
						end
					end
					REQ_RECV: begin
						if (h_ok && rdy_q[hs] && r_last_q) rdy_q[hs] <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

### tb/sv/udp_port_socket_table_test.sv
// testbench for the udp port socket table: directed and random requests with a scoreboard
`timescale 1ns / 1ps
`default_nettype none

module udp_port_socket_table_test import upst_pkg::*; ();

	typedef struct {
		logic [1:0]  kind;
		logic [15:0] port;
		logic [3:0]  handle;
		logic [31:0] src_ip;
		logic [15:0] peer_udp;
		logic [10:0] plen;
		logic [10:0] bidx;
		logic [7:0]  data;
		logic [15:0] bsize;
		logic        is_last;
	} request_t;

	typedef struct {
		logic [3:0]  status;
		logic [3:0]  handle;
		logic [10:0] rx_len;
		logic [31:0] ip;
		logic [15:0] sport;
		logic [7:0]  data;
		logic [3:0]  count;
	} reply_t;

	class socket_scoreboard;
		bit          used [SOCKETS];
		logic [15:0] lport [SOCKETS];
		logic [31:0] peer_ip [SOCKETS];
		logic [15:0] peer_port [SOCKETS];
		logic [10:0] pkt_len [SOCKETS];
		bit          ready [SOCKETS];
		logic [7:0]  store [SOCKETS*MAX_PAYLOAD];
		bit          written [SOCKETS*MAX_PAYLOAD];
		logic [15:0] eph_ptr;
		reply_t      pending_replies [$];
		int          fails;

		function new();
			for (int i = 0; i < SOCKETS; i++) begin
				drop_slot(i);
			end
			eph_ptr = EPH_BASE;
			fails = 0;
		endfunction

		function void drop_slot(int i);
			used[i] = 0;
			lport[i] = 0;
			peer_ip[i] = 0;
			peer_port[i] = 0;
			pkt_len[i] = 0;
			ready[i] = 0;
		endfunction

		// slot index + 1 of the socket bound to p, 0 if none
		function int slot_of_port(logic [15:0] p);
			for (int i = 0; i < SOCKETS; i++) begin
				if (used[i] && lport[i] == p) return i + 1;
			end
			return 0;
		endfunction

		function int slot_of_handle(logic [3:0] h);
			if (h == 0 || h > SOCKETS) return 0;
			if (!used[h - 1]) return 0;
			return h;
		endfunction

		function int readable(int k, logic [15:0] bsize);
			return (pkt_len[k] > bsize) ? bsize : pkt_len[k];
		endfunction

		// a receive that would read a never written payload byte
		function bit reads_unwritten(request_t r);
			int s;
			s = slot_of_handle(r.handle);
			if (r.kind != REQ_RECV || s == 0 || !ready[s - 1]) return 0;
			if (r.bidx >= readable(s - 1, r.bsize) || r.bidx >= MAX_PAYLOAD) return 0;
			return !written[(s - 1) * MAX_PAYLOAD + r.bidx];
		endfunction

		function void note_request(request_t r);
			reply_t      e;
			logic [15:0] lp;
			logic [15:0] cand;
			int          s;
			int          k;
			e = '{default: '0};
			case (r.kind)
				REQ_OPEN: begin
					lp = r.port;
					if (lp == 0) begin
						for (int i = 0; i < SOCKETS; i++) begin
							cand = eph_ptr + i[15:0];
							if (slot_of_port(cand) == 0) begin
								lp = cand;
								eph_ptr = cand + 16'd1;
								break;
							end
						end
					end
					if (lp == 0 || slot_of_port(lp) != 0) begin
						e.status = ST_BUSY;
					end else begin
						e.status = ST_FULL;
						for (int i = 0; i < SOCKETS; i++) begin
							if (!used[i]) begin
								drop_slot(i);
								used[i] = 1;
								lport[i] = lp;
								e.status = ST_OPENED;
								e.handle = 4'(i + 1);
								break;
							end
						end
					end
				end
				REQ_CLOSE: begin
					s = slot_of_handle(r.handle);
					if (s != 0) begin
						drop_slot(s - 1);
						e.status = ST_CLOSED;
					end else begin
						e.status = ST_BADH;
					end
				end
				REQ_DELIV: begin
					s = (r.plen <= MAX_PAYLOAD) ? slot_of_port(r.port) : 0;
					if (s == 0) begin
						e.status = ST_DROPPED;
					end else begin
						k = s - 1;
						if (r.bidx < r.plen) begin
							store[k * MAX_PAYLOAD + r.bidx] = r.data;
							written[k * MAX_PAYLOAD + r.bidx] = 1;
						end
						if (r.is_last) begin
							peer_ip[k] = r.src_ip;
							peer_port[k] = r.peer_udp;
							pkt_len[k] = r.plen;
							ready[k] = 1;
						end
						e.status = ST_QUEUED;
					end
				end
				default: begin
					s = slot_of_handle(r.handle);
					if (s == 0) begin
						e.status = ST_BADRECV;
					end else if (!ready[s - 1]) begin
						e.status = ST_NODATA;
					end else begin
						k = s - 1;
						e.rx_len = 11'(readable(k, r.bsize));
						if (r.bidx < e.rx_len && r.bidx < MAX_PAYLOAD)
							e.data = store[k * MAX_PAYLOAD + r.bidx];
						e.ip = peer_ip[k];
						e.sport = peer_port[k];
						if (r.is_last) ready[k] = 0;
						e.status = ST_BYTE;
					end
				end
			endcase
			for (int i = 0; i < SOCKETS; i++) begin
				if (used[i]) e.count++;
			end
			pending_replies.push_back(e);
		endfunction

		function void check_reply(reply_t a);
			reply_t e;
			if (pending_replies.size() == 0) begin
				$error("unexpected reply, status %0d", a.status);
				fails++;
				return;
			end
			e = pending_replies.pop_front();
			if (a.status !== e.status) begin
				$error("status exp %0d got %0d", e.status, a.status); fails++;
			end
			if (a.handle !== e.handle) begin
				$error("handle_out exp %0d got %0d", e.handle, a.handle); fails++;
			end
			if (a.rx_len !== e.rx_len) begin
				$error("rx_length exp %0d got %0d", e.rx_len, a.rx_len); fails++;
			end
			if (a.ip !== e.ip) begin
				$error("src_ip_out exp %h got %h", e.ip, a.ip); fails++;
			end
			if (a.sport !== e.sport) begin
				$error("peer_udp_out exp %0d got %0d", e.sport, a.sport); fails++;
			end
			if (a.data !== e.data) begin
				$error("data_out exp %h got %h", e.data, a.data); fails++;
			end
			if (a.count !== e.count) begin
				$error("open_count exp %0d got %0d", e.count, a.count); fails++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [15:0] port;
	logic [3:0]  handle;
	logic [31:0] src_ip;
	logic [15:0] peer_udp;
	logic [10:0] pkt_total;
	logic [10:0] byte_index;
	logic [7:0]  data_byte;
	logic [15:0] read_cap;
	logic        last;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  status;
	logic [3:0]  handle_out;
	logic [10:0] rx_length;
	logic [31:0] src_ip_out;
	logic [15:0] peer_udp_out;
	logic [7:0]  data_out;
	logic [3:0]  open_count;

	socket_scoreboard sb;
	int  sent;
	int  replies;
	bit  held;

	udp_port_socket_table u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .port(port), .handle(handle), .src_ip(src_ip),
		.peer_udp(peer_udp), .pkt_total(pkt_total), .byte_index(byte_index),
		.data_byte(data_byte), .read_cap(read_cap), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .handle_out(handle_out), .rx_length(rx_length),
		.src_ip_out(src_ip_out), .peer_udp_out(peer_udp_out), .data_out(data_out),
		.open_count(open_count)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic request_t random_request();
		request_t r;
		r.kind = 2'($urandom_range(0, 3));
		r.port = 16'($urandom_range(0, 65535));
		r.handle = 4'($urandom_range(0, 15));
		r.src_ip = $urandom;
		r.peer_udp = 16'($urandom_range(0, 65535));
		r.plen = 11'($urandom_range(0, 2047));
		r.bidx = 11'($urandom_range(0, 2047));
		r.data = 8'($urandom_range(0, 255));
		r.bsize = 16'($urandom_range(0, 65535));
		r.is_last = 1'($urandom_range(0, 1));
		return r;
	endfunction

	task automatic send(request_t r);
		if (sb.reads_unwritten(r)) r.bidx = 11'h7ff;
		if (!(sent >= 800 && sent < 1000) && $urandom_range(0, 99) < 37) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1;
		req_type <= r.kind;
		port <= r.port;
		handle <= r.handle;
		src_ip <= r.src_ip;
		peer_udp <= r.peer_udp;
		pkt_total <= r.plen;
		byte_index <= r.bidx;
		data_byte <= r.data;
		read_cap <= r.bsize;
		last <= r.is_last;
		do @(posedge clk); while (!in_ready);
		sb.note_request(r);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending_replies.size() != 0) @(posedge clk);
	endtask

	task automatic open_port(logic [15:0] p);
		request_t r;
		r = random_request();
		r.kind = REQ_OPEN;
		r.port = p;
		send(r);
	endtask

	task automatic close_handle(logic [3:0] h);
		request_t r;
		r = random_request();
		r.kind = REQ_CLOSE;
		r.handle = h;
		send(r);
	endtask

	// long packets carry only their first and last four bytes
	task automatic deliver_packet(logic [15:0] p, logic [10:0] plen, logic [31:0] ip,
			logic [15:0] sp);
		request_t r;
		int       n;
		int       idx;
		n = (plen == 0) ? 1 : (plen > 16) ? 8 : int'(plen);
		for (int i = 0; i < n; i++) begin
			idx = (plen > 16 && i >= 4) ? int'(plen) - 8 + i : i;
			r = random_request();
			r.kind = REQ_DELIV;
			r.port = p;
			r.plen = plen;
			r.src_ip = ip;
			r.peer_udp = sp;
			r.bidx = 11'(idx);
			r.is_last = (i == n - 1);
			send(r);
		end
	endtask

	task automatic receive_run(logic [3:0] h, logic [15:0] bsize, int n);
		request_t r;
		for (int i = 0; i < n; i++) begin
			r = random_request();
			r.kind = REQ_RECV;
			r.handle = h;
			r.bsize = bsize;
			r.bidx = 11'(i);
			r.is_last = (i == n - 1);
			send(r);
		end
	endtask

	task automatic close_all();
		for (int i = 1; i <= SOCKETS; i++) begin
			close_handle(4'(i));
		end
	endtask

	task automatic directed_part();
		logic [15:0] base;
		receive_run(0, 16'hffff, 1);
		close_handle(0);
		close_handle(15);
		open_port(0);
		open_port(16'hffff);
		open_port(16'hffff);
		open_port(1);
		deliver_packet(7, 3, 32'h01020304, 5);
		deliver_packet(16'hffff, 11'd1025, 32'h0, 0);
		begin
			request_t r;
			r = random_request();
			r.kind = REQ_DELIV;
			r.port = 16'hffff;
			r.plen = 3;
			r.bidx = 5;
			r.is_last = 0;
			send(r);
		end
		deliver_packet(16'hffff, 3, 32'hffffffff, 16'hffff);
		receive_run(2, 2, 3);
		receive_run(2, 16'hffff, 1);
		close_handle(2);
		receive_run(2, 16'hffff, 1);
		close_all();
		// occupy every ephemeral candidate, then a free one with a full table
		base = sb.eph_ptr;
		for (int i = 0; i < SOCKETS; i++) open_port(16'(base + i));
		open_port(0);
		open_port(5);
		close_handle(1);
		open_port(9);
		open_port(0);
		close_all();
	endtask

	task automatic random_part();
		int       pick;
		int       s;
		int       n;
		logic [15:0] bs;
		logic [10:0] plen;
		while (sent < 1100) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				case ($urandom_range(0, 3))
					0: open_port(0);
					1: open_port(16'($urandom_range(0, 65535)));
					default: open_port(16'(100 + $urandom_range(0, 9)));
				endcase
			end else if (pick < 25) begin
				close_handle(4'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
					: $urandom_range(1, SOCKETS)));
			end else if (pick < 55) begin
				s = $urandom_range(0, SOCKETS - 1);
				pick = $urandom_range(0, 99);
				plen = 11'((pick < 2) ? $urandom_range(900, 1024)
					: (pick < 5) ? $urandom_range(1025, 2047) : $urandom_range(0, 12));
				deliver_packet(($urandom_range(0, 4) == 0 || !sb.used[s])
					? 16'(100 + $urandom_range(0, 9)) : sb.lport[s],
					plen, $urandom, 16'($urandom_range(0, 65535)));
			end else if (pick < 88) begin
				s = $urandom_range(1, SOCKETS);
				bs = 16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
					: $urandom_range(0, 14));
				n = sb.ready[s - 1] ? sb.readable(s - 1, bs) : 1;
				if (n > 16 || n == 0) n = $urandom_range(1, 16);
				if ($urandom_range(0, 4) == 0) n += 2;
				receive_run(4'(s), bs, n);
			end else begin
				send(random_request());
			end
			if (sent > 600 && sent < 640) drain();
		end
	endtask

	initial begin
		sb = new();
		sent = 0;
		arst_n = 0;
		in_valid = 0;
		req_type = REQ_OPEN;
		port = 0;
		handle = 0;
		src_ip = 0;
		peer_udp = 0;
		pkt_total = 0;
		byte_index = 0;
		data_byte = 0;
		read_cap = 0;
		last = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed_part();
		drain();
		random_part();
		drain();
		repeat (30) @(posedge clk);
		if (sb.fails == 0 && sb.pending_replies.size() == 0)
			$display("PASS udp_port_socket_table");
		else
			$display("FAIL udp_port_socket_table");
		$finish;
	end

	// result side: random stalls, one long hold-off, and a calm stretch
	initial begin
		reply_t a;
		replies = 0;
		held = 0;
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				a.status = status;
				a.handle = handle_out;
				a.rx_len = rx_length;
				a.ip = src_ip_out;
				a.sport = peer_udp_out;
				a.data = data_out;
				a.count = open_count;
				sb.check_reply(a);
				replies++;
			end
			if (replies == 400 && !held) begin
				held = 1;
				out_ready <= 0;
				repeat (300) @(posedge clk);
			end
			out_ready <= (replies >= 700 && replies < 900) || ($urandom_range(0, 99) >= 37);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
				quiet = 0;
			else
				quiet++;
			if (quiet >= 5000) begin
				$display("FAIL udp_port_socket_table");
				$finish;
			end
		end
	end
endmodule

`default_nettype wire
